// ----- hdl/lrpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lrpc_pkg;

    // Field widths
    localparam int IDX_W      = 10;
    localparam int STEP_W     = 9;
    localparam int CH_W       = 8;
    localparam int CHANNELS   = 3;
    localparam int RGB_W      = CHANNELS * CH_W;
    localparam int COLOR_REGS = 6;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = RGB_W;
    localparam int IN_DATA_W  = 16;

    // Default wheel geometry
    localparam int SECTIONS_DEF   = 6;
    localparam int SOLO_WIDTH_DEF = 16;
    localparam int FADE_WIDTH_DEF = 48;

    // Register reset values
    localparam logic [STEP_W-1:0] SPEED_RST    = STEP_W'(1);
    localparam logic [STEP_W-1:0] COMPRESS_RST = STEP_W'(1);
    localparam logic [RGB_W-1:0]  COLOR_RST [COLOR_REGS] = '{
        24'hFF0000, 24'hFFFF00, 24'h00FF00, 24'h00FFFF, 24'h0000FF, 24'hFF00FF
    };

    // Register map
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SPEED    = 3'd0,
        REG_COMPRESS = 3'd1,
        REG_COLOR0   = 3'd2,
        REG_COLOR1   = 3'd3,
        REG_COLOR2   = 3'd4,
        REG_COLOR3   = 3'd5,
        REG_COLOR4   = 3'd6,
        REG_COLOR5   = 3'd7
    } cfg_reg_t;

    // Input item kind
    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_TICK  = 1'b1
    } cmd_t;

    typedef logic [CH_W-1:0] chan_t;

endpackage

`default_nettype wire

// ----- hdl/led_rainbow_pixel_color_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Rainbow color wheel for an LED strip.
// Input stream (s_*): s_tuser is the item kind (tick or pixel), s_tdata[9:0]
// the pixel index. A tick advances the wheel phase by speed and gives no
// output; a pixel item gives one transfer on the output stream (m_*) with
// the pixel color, red in m_tdata[7:0], green [15:8], blue [23:16].
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 speed,
// 1 compress, 2..7 section colors, packed red 23:16, green 15:8, blue 7:0).
// Write only while no item is in flight.
// Throughput: one item per clock while s_tready is high. The result of a
// pixel passes, after the input register, through nine register stages
// (index multiply, reciprocal quotient, remainder, phase add, section split,
// blend setup, weight multiply, reciprocal divide, output register) on its
// way to m_tvalid.
// Stall: a two-entry output (output register plus skid register) absorbs
// the pipeline; s_tready drops only once the skid entry is occupied, and
// the whole pipeline then holds in place.
// Reset: pipeline empties, phase goes to 0, registers take their defaults.

module led_rainbow_pixel_color_core #(
    parameter int SECTIONS   = lrpc_pkg::SECTIONS_DEF,
    parameter int SOLO_WIDTH = lrpc_pkg::SOLO_WIDTH_DEF,
    parameter int FADE_WIDTH = lrpc_pkg::FADE_WIDTH_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // configuration write port
    input  wire                                 cfg_we,
    input  wire  [lrpc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire  [lrpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input stream
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [lrpc_pkg::IN_DATA_W-1:0]      s_tdata,   // [9:0] pixel_index
    input  wire                                 s_tuser,   // [0] cmd
    // output stream
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [lrpc_pkg::RGB_W-1:0]          m_tdata    // [7:0] red, [15:8] green,
                                                           // [23:16] blue
);

    localparam int IDX_W    = lrpc_pkg::IDX_W;
    localparam int STEP_W   = lrpc_pkg::STEP_W;
    localparam int CH_W     = lrpc_pkg::CH_W;
    localparam int CHANNELS = lrpc_pkg::CHANNELS;
    localparam int RGB_W    = lrpc_pkg::RGB_W;
    localparam int NREGS    = lrpc_pkg::COLOR_REGS;

    localparam int SECTION_STEPS = SOLO_WIDTH + FADE_WIDTH;
    localparam int WHEEL_LENGTH  = SECTIONS * SECTION_STEPS;
    localparam int PHASE_W       = $clog2(WHEEL_LENGTH);
    localparam int OFF_W         = (SECTION_STEPS > 1) ? $clog2(SECTION_STEPS) : 1;
    localparam int SEC_W         = $clog2(SECTIONS);
    localparam int KW            = $clog2(FADE_WIDTH + 1);

    // x mod WHEEL_LENGTH for x < 2^VAL_W via reciprocal multiply
    localparam int     VAL_W  = IDX_W + STEP_W;
    localparam int     MOD_SH = VAL_W + PHASE_W;
    localparam int     MOD_MW = VAL_W + 2;
    localparam longint MOD_M  = ((longint'(1) << MOD_SH) + WHEEL_LENGTH - 1) / WHEEL_LENGTH;

    // x / FADE_WIDTH for x < 2^PROD_W via reciprocal multiply
    localparam int     PROD_W  = KW + CH_W;
    localparam int     FADE_LG = $clog2(FADE_WIDTH);
    localparam int     DIV_SH  = PROD_W + FADE_LG;
    localparam int     DIV_MW  = PROD_W + 2;
    localparam longint DIV_M   = ((longint'(1) << DIV_SH) + FADE_WIDTH - 1) / FADE_WIDTH;

    localparam logic [MOD_MW-1:0]  MOD_M_C = MOD_MW'(MOD_M);
    localparam logic [DIV_MW-1:0]  DIV_M_C = DIV_MW'(DIV_M);
    localparam logic [PHASE_W:0]   LEN_C   = (PHASE_W + 1)'(WHEEL_LENGTH);
    localparam logic [PHASE_W:0]   STEPS_C = (PHASE_W + 1)'(SECTION_STEPS);
    localparam logic [OFF_W-1:0]   SOLO_C  = OFF_W'(SOLO_WIDTH);
    localparam logic [KW-1:0]      FADE_C  = KW'(FADE_WIDTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [STEP_W-1:0] speed_reg;
    logic [STEP_W-1:0] compress_reg;
    logic [RGB_W-1:0]  color_reg [NREGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg    <= lrpc_pkg::SPEED_RST;
            compress_reg <= lrpc_pkg::COMPRESS_RST;
            for (int i = 0; i < NREGS; i++)
            begin
                color_reg[i] <= lrpc_pkg::COLOR_RST[i];
            end
        end
        else if (cfg_we)
        begin
            unique case (lrpc_pkg::cfg_reg_t'(cfg_addr))
                lrpc_pkg::REG_SPEED:
                    speed_reg <= cfg_wdata[STEP_W-1:0];
                lrpc_pkg::REG_COMPRESS:
                    compress_reg <= cfg_wdata[STEP_W-1:0];
                lrpc_pkg::REG_COLOR0, lrpc_pkg::REG_COLOR1, lrpc_pkg::REG_COLOR2,
                lrpc_pkg::REG_COLOR3, lrpc_pkg::REG_COLOR4, lrpc_pkg::REG_COLOR5:
                    color_reg[lrpc_pkg::CFG_ADDR_W'(cfg_addr - lrpc_pkg::REG_COLOR0)]
                        <= cfg_wdata[RGB_W-1:0];
            endcase
        end
    end

    // following section's color, wrapping to section 0
    logic [RGB_W-1:0] color_nxt [SECTIONS];
    for (genvar g = 0; g < SECTIONS; g++)
    begin : g_nxt
        assign color_nxt[g] = color_reg[(g + 1) % SECTIONS];
    end

    // ------------------------------------------------------------------
    // Pipeline control: everything advances unless the skid entry is full
    // ------------------------------------------------------------------
    logic en;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg, s8_valid_reg, s9_valid_reg;
    lrpc_pkg::cmd_t s1_cmd_reg, s2_cmd_reg, s3_cmd_reg, s4_cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            // ticks end at the phase stage
            s5_valid_reg <= s4_valid_reg && (s4_cmd_reg == lrpc_pkg::CMD_PIXEL);
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
            s9_valid_reg <= s8_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] s1_idx_reg;

    // Stage 2: wheel step count (pixel offset or tick advance)
    logic [VAL_W-1:0] s2_val_next, s2_val_reg;

    assign s2_val_next = (s1_cmd_reg == lrpc_pkg::CMD_TICK) ? VAL_W'(speed_reg)
                       : VAL_W'(s1_idx_reg) * VAL_W'(compress_reg);

    // Stage 3: quotient by wheel length
    logic [VAL_W+MOD_MW-1:0] s3_mul;
    logic [VAL_W-1:0]        s3_quo_next, s3_quo_reg, s3_val_reg;

    assign s3_mul      = (VAL_W + MOD_MW)'(s2_val_reg) * (VAL_W + MOD_MW)'(MOD_M_C);
    assign s3_quo_next = VAL_W'(s3_mul >> MOD_SH);

    // Stage 4: remainder
    logic [VAL_W+PHASE_W:0] s4_mul;
    logic [PHASE_W-1:0]     s4_rem_next, s4_rem_reg;

    assign s4_mul      = (VAL_W + PHASE_W + 1)'(s3_quo_reg) * (VAL_W + PHASE_W + 1)'(LEN_C);
    assign s4_rem_next = PHASE_W'(s3_val_reg - VAL_W'(s4_mul));

    // Stage 5: phase add, one conditional subtract keeps it on the wheel
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [PHASE_W:0]   s5_sum;
    logic [PHASE_W-1:0] s5_pos_next, s5_pos_reg;

    assign s5_sum      = {1'b0, phase_reg} + {1'b0, s4_rem_reg};
    assign s5_pos_next = (s5_sum >= LEN_C) ? PHASE_W'(s5_sum - LEN_C) : PHASE_W'(s5_sum);
    assign phase_next  = s5_pos_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (en && s4_valid_reg && (s4_cmd_reg == lrpc_pkg::CMD_TICK))
        begin
            phase_reg <= phase_next;
        end
    end

    // Stage 6: section and offset within it
    logic [SEC_W-1:0] s6_sec_next, s6_sec_reg;
    logic [OFF_W-1:0] s6_off_next, s6_off_reg;
    logic [PHASE_W:0] s6_base;

    always_comb
    begin
        s6_sec_next = '0;
        s6_base     = '0;
        for (int k = 1; k < SECTIONS; k++)
        begin
            if ({1'b0, s5_pos_reg} >= (PHASE_W + 1)'(k * SECTION_STEPS))
            begin
                s6_sec_next = SEC_W'(k);
                s6_base     = (PHASE_W + 1)'(k * SECTION_STEPS);
            end
        end
        s6_off_next = OFF_W'({1'b0, s5_pos_reg} - s6_base);
    end

    // Stage 7: blend setup per channel (weight, span, base)
    logic [RGB_W-1:0]  s7_cur, s7_nxt;
    logic              s7_solo;
    logic [KW-1:0]     s7_foff;
    logic [KW-1:0]     s7_k_next    [CHANNELS];
    logic [CH_W-1:0]   s7_diff_next [CHANNELS];
    lrpc_pkg::chan_t   s7_base_next [CHANNELS];
    logic [KW-1:0]     s7_k_reg     [CHANNELS];
    logic [CH_W-1:0]   s7_diff_reg  [CHANNELS];
    lrpc_pkg::chan_t   s7_base_reg  [CHANNELS];

    assign s7_cur  = color_reg[s6_sec_reg];
    assign s7_nxt  = color_nxt[s6_sec_reg];
    assign s7_solo = s6_off_reg < SOLO_C;
    assign s7_foff = KW'(s6_off_reg - SOLO_C);

    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            // channel 0 is red in the top byte
            if (s7_solo || (s7_cur[RGB_W-1-ch*CH_W -: CH_W] == s7_nxt[RGB_W-1-ch*CH_W -: CH_W]))
            begin
                s7_k_next[ch]    = '0;
                s7_diff_next[ch] = '0;
                s7_base_next[ch] = s7_cur[RGB_W-1-ch*CH_W -: CH_W];
            end
            else if (s7_cur[RGB_W-1-ch*CH_W -: CH_W] < s7_nxt[RGB_W-1-ch*CH_W -: CH_W])
            begin
                s7_k_next[ch]    = s7_foff;
                s7_diff_next[ch] = s7_nxt[RGB_W-1-ch*CH_W -: CH_W]
                                 - s7_cur[RGB_W-1-ch*CH_W -: CH_W];
                s7_base_next[ch] = s7_cur[RGB_W-1-ch*CH_W -: CH_W];
            end
            else
            begin
                // falling channel: measured from the far end
                s7_k_next[ch]    = FADE_C - s7_foff;
                s7_diff_next[ch] = s7_cur[RGB_W-1-ch*CH_W -: CH_W]
                                 - s7_nxt[RGB_W-1-ch*CH_W -: CH_W];
                s7_base_next[ch] = s7_nxt[RGB_W-1-ch*CH_W -: CH_W];
            end
        end
    end

    // Stage 8: weight times span
    logic [PROD_W-1:0] s8_prod_next [CHANNELS];
    logic [PROD_W-1:0] s8_prod_reg  [CHANNELS];
    lrpc_pkg::chan_t   s8_base_reg  [CHANNELS];

    // Stage 9: divide by fade width
    logic [PROD_W+DIV_MW-1:0] s9_mul      [CHANNELS];
    lrpc_pkg::chan_t          s9_quo_next [CHANNELS];
    lrpc_pkg::chan_t          s9_quo_reg  [CHANNELS];
    lrpc_pkg::chan_t          s9_base_reg [CHANNELS];

    // Output: quotient plus base
    lrpc_pkg::chan_t  res_chan [CHANNELS];
    logic [RGB_W-1:0] result;

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_chan
        assign s8_prod_next[c] = PROD_W'(s7_k_reg[c]) * PROD_W'(s7_diff_reg[c]);
        assign s9_mul[c]       = (PROD_W + DIV_MW)'(s8_prod_reg[c])
                               * (PROD_W + DIV_MW)'(DIV_M_C);
        assign s9_quo_next[c]  = CH_W'(s9_mul[c] >> DIV_SH);
        assign res_chan[c]     = s9_quo_reg[c] + s9_base_reg[c];
        assign result[c*CH_W +: CH_W] = res_chan[c];
    end

    // Pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_idx_reg <= s_tdata[IDX_W-1:0];
            s1_cmd_reg <= lrpc_pkg::cmd_t'(s_tuser);
            s2_val_reg <= s2_val_next;
            s2_cmd_reg <= s1_cmd_reg;
            s3_quo_reg <= s3_quo_next;
            s3_val_reg <= s2_val_reg;
            s3_cmd_reg <= s2_cmd_reg;
            s4_rem_reg <= s4_rem_next;
            s4_cmd_reg <= s3_cmd_reg;
            s5_pos_reg <= s5_pos_next;
            s6_sec_reg <= s6_sec_next;
            s6_off_reg <= s6_off_next;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                s7_k_reg[ch]    <= s7_k_next[ch];
                s7_diff_reg[ch] <= s7_diff_next[ch];
                s7_base_reg[ch] <= s7_base_next[ch];
                s8_prod_reg[ch] <= s8_prod_next[ch];
                s8_base_reg[ch] <= s7_base_reg[ch];
                s9_quo_reg[ch]  <= s9_quo_next[ch];
                s9_base_reg[ch] <= s8_base_reg[ch];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid entry
    // ------------------------------------------------------------------
    logic [RGB_W-1:0] out_data_reg;
    logic [RGB_W-1:0] skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg  <= skid_valid_reg || s9_valid_reg;
            skid_valid_reg <= 1'b0;
        end
        else if (s9_valid_reg && en)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        else if (s9_valid_reg && en)
        begin
            skid_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // skid entry only fills behind a waiting output
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry occupied with empty output register");

    // phase stays on the wheel
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, phase_reg} < LEN_C)
        else $error("phase out of range");

    // section split leaves an offset inside the section
    assert property (@(posedge clk) disable iff (!rst_n)
        s6_valid_reg |-> ((PHASE_W + 1)'(s6_off_reg) < STEPS_C))
        else $error("section offset out of range");

endmodule

`default_nettype wire
